// ===== hdl/cmm_pkg.sv =====
package cmm_pkg;

    // input word kinds
    localparam logic [1:0] KIND_AXIS   = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_APPLY  = 2'd2;
    localparam logic [1:0] KIND_ENTRY  = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAP_EN  = 1'b0;
    localparam logic CFG_ENT_CNT = 1'b1;

    localparam int CFG_W = 5;

    // a pressed button reads as full scale
    localparam logic signed [15:0] FULL_SCALE = 16'sd32767;

    typedef struct packed {
        logic [1:0]          kind;
        logic [3:0]          control_number;
        logic signed [15:0]  control_value;
        logic [3:0]          entry_slot;
        logic                entry_from_button;
        logic [3:0]          entry_source;
        logic [14:0]         entry_threshold;
        logic signed [15:0]  entry_weight;
        logic signed [20:0]  entry_bias;
        logic [3:0]          entry_target;
        logic [15:0]         entry_button_mask;
    } t_in_word;

    typedef struct packed {
        logic [2:0]          virtual_axis;
        logic signed [31:0]  virtual_value;
        logic [15:0]         held_buttons;
        logic [15:0]         pressed_buttons;
        logic [15:0]         released_buttons;
        logic                last_of_run;
    } t_out_word;

    typedef struct packed {
        logic                from_button;
        logic [3:0]          source;
        logic [14:0]         threshold;
        logic signed [15:0]  weight;
        logic signed [20:0]  bias;
        logic [3:0]          target;
        logic [15:0]         mask;
    } t_entry;

    typedef struct packed {
        logic start;    // clear sums and held mask
        logic tbl_rd;   // read table entry at walk index
        logic val;      // dead zone / button value, read target sum
        logic mul;      // weight product
        logic acc;      // round, add bias, saturate, write sum
        logic fin;      // pressed / released masks
        logic emit_rd;  // read sum for output
        logic load;     // load output register
        logic last;     // final word of the run
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_VAL,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

endpackage

// ===== hdl/cmm_in_if.sv =====
interface cmm_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [3:0]          control_number;
    logic signed [15:0]  control_value;
    logic [3:0]          entry_slot;
    logic                entry_from_button;
    logic [3:0]          entry_source;
    logic [14:0]         entry_threshold;
    logic signed [15:0]  entry_weight;
    logic signed [20:0]  entry_bias;
    logic [3:0]          entry_target;
    logic [15:0]         entry_button_mask;

    modport source (
        output valid, kind, control_number, control_value, entry_slot,
               entry_from_button, entry_source, entry_threshold, entry_weight,
               entry_bias, entry_target, entry_button_mask,
        input  ready
    );

    modport sink (
        input  valid, kind, control_number, control_value, entry_slot,
               entry_from_button, entry_source, entry_threshold, entry_weight,
               entry_bias, entry_target, entry_button_mask,
        output ready
    );
endinterface

// ===== hdl/cmm_out_if.sv =====
interface cmm_out_if;
    logic                valid;
    logic                ready;
    logic [2:0]          virtual_axis;
    logic signed [31:0]  virtual_value;
    logic [15:0]         held_buttons;
    logic [15:0]         pressed_buttons;
    logic [15:0]         released_buttons;
    logic                last_of_run;

    modport source (
        output valid, virtual_axis, virtual_value, held_buttons,
               pressed_buttons, released_buttons, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, virtual_axis, virtual_value, held_buttons,
               pressed_buttons, released_buttons, last_of_run,
        output ready
    );
endinterface

// ===== hdl/control_mapping_mixer.sv =====
// Controller mapping mixer. Axis (kind 0) and button (kind 1) words update the
// stored control state and entry words (kind 3) load the mapping table. An apply
// word (kind 2) with mapping enabled walks the first entry_count table entries
// (table read, dead zone, weight multiply, round/bias/saturating accumulate for
// each), builds the button edge masks, then emits one word per virtual axis (sum
// read, output register load for each), last_of_run set on the final one. With
// mapping disabled the walk and edge-mask step are skipped and the stored sums
// are emitted. An output stall holds the emit sequence; no input is taken until
// the last word of an apply sits in the output register.
// Configuration writes take effect at once and belong only to idle periods.
module control_mapping_mixer
    import cmm_pkg::*;
#(
    parameter int AXIS_COUNT    = 8,
    parameter int BUTTON_COUNT  = 16,
    parameter int TABLE_ENTRIES = 16,
    parameter int VIRTUAL_AXES  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmm_in_if.sink            i_in,
    cmm_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW = (VIRTUAL_AXES > 1) ? $clog2(VIRTUAL_AXES) : 1;

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [TW-1:0] w_idx;
    logic [SW-1:0] w_k;
    logic          w_ready;
    logic          w_take;
    t_in_word      w_in;
    t_out_word     w_out;
    logic          w_ovld;

    assign w_in = '{
        kind:              i_in.kind,
        control_number:    i_in.control_number,
        control_value:     i_in.control_value,
        entry_slot:        i_in.entry_slot,
        entry_from_button: i_in.entry_from_button,
        entry_source:      i_in.entry_source,
        entry_threshold:   i_in.entry_threshold,
        entry_weight:      i_in.entry_weight,
        entry_bias:        i_in.entry_bias,
        entry_target:      i_in.entry_target,
        entry_button_mask: i_in.entry_button_mask
    };

    assign w_take     = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    cmm_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VIRTUAL_AXES  (VIRTUAL_AXES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_kind     (i_in.kind),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sts      (w_sts),
        .o_ready    (w_ready),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx),
        .o_k        (w_k)
    );

    cmm_dp #(
        .AXIS_COUNT    (AXIS_COUNT),
        .BUTTON_COUNT  (BUTTON_COUNT),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VIRTUAL_AXES  (VIRTUAL_AXES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_word  (w_in),
        .i_cmd   (w_cmd),
        .i_idx   (w_idx),
        .i_k     (w_k),
        .i_ready (o_out.ready),
        .o_sts   (w_sts),
        .o_valid (w_ovld),
        .o_word  (w_out)
    );

    assign o_out.valid            = w_ovld;
    assign o_out.virtual_axis     = w_out.virtual_axis;
    assign o_out.virtual_value    = w_out.virtual_value;
    assign o_out.held_buttons     = w_out.held_buttons;
    assign o_out.pressed_buttons  = w_out.pressed_buttons;
    assign o_out.released_buttons = w_out.released_buttons;
    assign o_out.last_of_run      = w_out.last_of_run;

    // no word taken while the walk or emit sequence is running
    a_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ready |-> !(w_cmd.tbl_rd || w_cmd.acc || w_cmd.emit_rd || w_cmd.load))
        else $error("input ready while sequencer busy");

    // an accepted apply always makes the block busy
    a_apply_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in.kind == KIND_APPLY) |=> !w_ready)
        else $error("apply did not start a run");

    // the final word of a run returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load && w_cmd.last) |=> (w_ready && o_out.valid && o_out.last_of_run))
        else $error("run did not end after last word");

endmodule

// ===== hdl/cmm_ctrl.sv =====
module cmm_ctrl
    import cmm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int VIRTUAL_AXES  = 8,
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int SW = (VIRTUAL_AXES > 1) ? $clog2(VIRTUAL_AXES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_sts              i_sts,
    output logic              o_ready,
    output t_cmd              o_cmd,
    output logic [TW-1:0]     o_idx,
    output logic [SW-1:0]     o_k
);

    localparam int NW = TW + 1;

    t_state          r_state, n_state;
    logic            r_map_en;
    logic [CFG_W-1:0] r_ent_cnt;
    logic [NW-1:0]   r_idx, n_idx;
    logic [SW-1:0]   r_k, n_k;
    logic [NW-1:0]   w_n;
    logic            w_apply;
    logic            w_k_last;
    logic            w_idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_en  <= 1'b0;
            r_ent_cnt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_EN:  r_map_en  <= i_cfg_data[0];
                CFG_ENT_CNT: r_ent_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entries walked: count clipped to table depth
    assign w_n = (32'(r_ent_cnt) > TABLE_ENTRIES) ? NW'(TABLE_ENTRIES) : NW'(r_ent_cnt);

    assign w_apply    = i_valid && (r_state == ST_IDLE) && (i_kind == KIND_APPLY);
    assign w_k_last   = (32'(r_k) == VIRTUAL_AXES - 1);
    assign w_idx_last = ((r_idx + NW'(1)) == w_n);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_apply) begin
                    if (!r_map_en)          n_state = ST_EMIT_RD;
                    else if (w_n == '0)     n_state = ST_FIN;
                    else                    n_state = ST_RD;
                end
            end
            ST_RD:       n_state = ST_VAL;
            ST_VAL:      n_state = ST_MUL;
            ST_MUL:      n_state = ST_ACC;
            ST_ACC:      n_state = w_idx_last ? ST_FIN : ST_RD;
            ST_FIN:      n_state = ST_EMIT_RD;
            ST_EMIT_RD:  n_state = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (i_sts.out_free) begin
                    n_state = w_k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        n_k   = r_k;
        if (w_apply) begin
            n_idx = '0;
            n_k   = '0;
        end
        if (r_state == ST_ACC) n_idx = r_idx + NW'(1);
        if (r_state == ST_EMIT_OUT && i_sts.out_free) n_k = r_k + SW'(1);
    end

    always_comb begin
        o_cmd         = '0;
        o_ready       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.start = w_apply && r_map_en;
            end
            ST_RD:       o_cmd.tbl_rd  = 1'b1;
            ST_VAL:      o_cmd.val     = 1'b1;
            ST_MUL:      o_cmd.mul     = 1'b1;
            ST_ACC:      o_cmd.acc     = 1'b1;
            ST_FIN:      o_cmd.fin     = 1'b1;
            ST_EMIT_RD:  o_cmd.emit_rd = 1'b1;
            ST_EMIT_OUT: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.last = i_sts.out_free && w_k_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
        end
    end

    assign o_idx = r_idx[TW-1:0];
    assign o_k   = r_k;

endmodule

// ===== hdl/cmm_dp.sv =====
module cmm_dp
    import cmm_pkg::*;
#(
    parameter int AXIS_COUNT    = 8,
    parameter int BUTTON_COUNT  = 16,
    parameter int TABLE_ENTRIES = 16,
    parameter int VIRTUAL_AXES  = 8,
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int SW = (VIRTUAL_AXES > 1) ? $clog2(VIRTUAL_AXES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  t_in_word      i_word,
    input  t_cmd          i_cmd,
    input  logic [TW-1:0] i_idx,
    input  logic [SW-1:0] i_k,
    input  logic          i_ready,
    output t_sts          o_sts,
    output logic          o_valid,
    output t_out_word     o_word
);

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    logic signed [15:0]    r_pos [AXIS_COUNT];
    logic [BUTTON_COUNT-1:0] r_btn;
    t_entry                r_tbl [TABLE_ENTRIES];
    t_entry                r_ent;
    logic signed [31:0]    r_sum [VIRTUAL_AXES];
    logic [VIRTUAL_AXES-1:0] r_sum_vld;
    logic signed [31:0]    r_sum_rd;
    logic                  r_sum_rv;
    logic                  r_tgt_ok;
    logic signed [15:0]    r_v;
    logic signed [31:0]    r_prod;
    logic [15:0]           r_held;
    logic [15:0]           r_old;
    logic [15:0]           r_pressed;
    logic [15:0]           r_released;
    logic                  r_ovld;
    t_out_word             r_oword;

    logic signed [15:0]    w_pos;
    logic                  w_btn;
    logic signed [17:0]    w_p18;
    logic signed [17:0]    w_th18;
    logic signed [15:0]    w_v;
    logic [SW-1:0]         w_sum_addr;
    logic signed [32:0]    w_rnd;
    logic signed [24:0]    w_scl;
    logic signed [25:0]    w_add;
    logic signed [31:0]    w_cur;
    logic signed [32:0]    w_tot;
    logic signed [31:0]    w_sat;

    // physical controls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_COUNT; i++) r_pos[i] <= '0;
            r_btn <= '0;
        end else if (i_take) begin
            if (i_word.kind == KIND_AXIS && 32'(i_word.control_number) < AXIS_COUNT) begin
                r_pos[AW'(i_word.control_number)] <= i_word.control_value;
            end
            if (i_word.kind == KIND_BUTTON && 32'(i_word.control_number) < BUTTON_COUNT) begin
                r_btn[BW'(i_word.control_number)] <= (i_word.control_value > 16'sd0);
            end
        end
    end

    // mapping table
    always_ff @(posedge i_clk) begin
        if (i_take && i_word.kind == KIND_ENTRY && 32'(i_word.entry_slot) < TABLE_ENTRIES) begin
            r_tbl[TW'(i_word.entry_slot)] <= '{
                from_button: i_word.entry_from_button,
                source:      i_word.entry_source,
                threshold:   i_word.entry_threshold,
                weight:      i_word.entry_weight,
                bias:        i_word.entry_bias,
                target:      i_word.entry_target,
                mask:        i_word.entry_button_mask
            };
        end
        if (i_cmd.tbl_rd) r_ent <= r_tbl[i_idx];
    end

    // source value with dead zone taken out
    assign w_pos  = (32'(r_ent.source) < AXIS_COUNT) ? r_pos[AW'(r_ent.source)] : 16'sd0;
    assign w_btn  = (32'(r_ent.source) < BUTTON_COUNT) && r_btn[BW'(r_ent.source)];
    assign w_p18  = 18'(w_pos);
    assign w_th18 = signed'({3'b000, r_ent.threshold});

    always_comb begin
        w_v = 16'sd0;
        if (r_ent.from_button) begin
            if (w_btn) w_v = FULL_SCALE;
        end else if (w_p18 > w_th18) begin
            w_v = 16'(w_p18 - w_th18);
        end else if (-w_p18 > w_th18) begin
            w_v = 16'(w_p18 + w_th18);
        end
    end

    assign w_sum_addr = i_cmd.emit_rd ? i_k : SW'(r_ent.target);

    // round half up, floor shift by 8, add bias and current sum, saturate
    assign w_rnd = 33'(r_prod) + 33'sd128;
    assign w_scl = 25'(w_rnd >>> 8);
    assign w_add = 26'(w_scl) + 26'(r_ent.bias);
    assign w_cur = r_sum_rv ? r_sum_rd : 32'sd0;
    assign w_tot = 33'(w_cur) + 33'(w_add);

    always_comb begin
        if (w_tot[32] != w_tot[31]) begin
            w_sat = w_tot[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_sat = w_tot[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.val || i_cmd.emit_rd) r_sum_rd <= r_sum[w_sum_addr];
        if (i_cmd.acc && r_tgt_ok) r_sum[SW'(r_ent.target)] <= w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.val) begin
            r_v      <= w_v;
            r_tgt_ok <= (32'(r_ent.target) < VIRTUAL_AXES);
        end
        if (i_cmd.mul) r_prod <= r_v * r_ent.weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld  <= '0;
            r_sum_rv   <= 1'b0;
            r_held     <= '0;
            r_old      <= '0;
            r_pressed  <= '0;
            r_released <= '0;
        end else begin
            if (i_cmd.start) begin
                r_sum_vld <= '0;
                r_old     <= r_held;
                r_held    <= '0;
            end
            if (i_cmd.val || i_cmd.emit_rd) r_sum_rv <= r_sum_vld[w_sum_addr];
            if (i_cmd.val && r_ent.from_button && w_btn) r_held <= r_held | r_ent.mask;
            if (i_cmd.acc && r_tgt_ok) r_sum_vld[SW'(r_ent.target)] <= 1'b1;
            if (i_cmd.fin) begin
                r_pressed  <= r_held & ~r_old;
                r_released <= r_old & ~r_held;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_oword <= '{
                virtual_axis:     3'(i_k),
                virtual_value:    w_cur,
                held_buttons:     r_held,
                pressed_buttons:  r_pressed,
                released_buttons: r_released,
                last_of_run:      i_cmd.last
            };
        end
    end

    assign o_sts.out_free = !r_ovld || i_ready;
    assign o_valid        = r_ovld;
    assign o_word         = r_oword;

endmodule
